@@ rtl/core/scfla_pkg.sv @@
// Shared types, codes and default sizes of the size-class free-list allocator.
package scfla_pkg;

    localparam int NUM_CLASSES_DEF = 128;
    localparam int HANDLE_BITS_DEF = 12;

    localparam int SIZE_W   = 20;
    localparam int HANDLE_W = 12;
    localparam int STATUS_W = 3;
    localparam int ROUND_W  = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_POPPED       = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_LARGE_ALLOC  = 3'd2,
        ST_ZERO         = 3'd3,
        ST_PUSHED       = 3'd4,
        ST_FREE_IGNORED = 3'd5,
        ST_LARGE_FREE   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_LINK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // clear one head entry
        logic load;     // take request, read head
        logic link_rd;  // read link of popped head
        logic finish;   // write back, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic need_link;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/core/size_class_free_list_allocator_unit.sv @@
// Top level of the size-class free-list allocator: sequencer plus datapath.
// Sequence: an accepted item reads its head entry at the accepting edge (registered); a
//   pop then reads the link of that head; the head write-back and the result register load
//   wait until the result register is free, so back-pressure on i_ready can stall an item.
// One item is in flight at a time: the next is taken only after the last is written back.
// Reset: synchronous, active low; then a clearing pass writes every head entry to
//   empty, during which o_ready is low.
module size_class_free_list_allocator_unit
    import scfla_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic [HANDLE_W-1:0] i_block_handle,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [HANDLE_W-1:0] o_granted_handle,
    output logic [STATUS_W-1:0] o_status,
    output logic [ROUND_W-1:0]  o_rounded_bytes
);

    // command and status between the sequencer and the datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    // The sequencer walks each item through head read, optional link read and
    // write-back. A finished item sits in the result register, so the next item
    // can be taken while that result still waits downstream.
    scfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Head table (one entry per class) and link memory (one entry per handle)
    // live in the datapath; only the head table is cleared after reset.
    scfla_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_opcode         (i_opcode),
        .i_size_bytes     (i_size_bytes),
        .i_block_handle   (i_block_handle),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_granted_handle (o_granted_handle),
        .o_status         (o_status),
        .o_rounded_bytes  (o_rounded_bytes)
    );

endmodule

@@ rtl/core/scfla_ctrl.sv @@
// Sequencer of the allocator: clearing pass, head read, link read, write-back.
module scfla_ctrl
    import scfla_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_HEAD;
            end
            S_HEAD: begin
                if (i_stat.need_link) begin
                    n_state = S_LINK;
                end else if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LINK: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_HEAD: begin
                o_cmd.link_rd = i_stat.need_link;
                o_cmd.finish  = !i_stat.need_link && i_stat.out_free;
            end
            S_LINK: o_cmd.finish = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/scfla_dp.sv @@
// Datapath of the allocator: request register, head table, link memory, result register.
module scfla_dp
    import scfla_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_opcode,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic [HANDLE_W-1:0] i_block_handle,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [HANDLE_W-1:0] o_granted_handle,
    output logic [STATUS_W-1:0] o_status,
    output logic [ROUND_W-1:0]  o_rounded_bytes
);

    localparam int CB        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LINK_DEPTH = 1 << HANDLE_BITS;
    localparam logic [CB-1:0]   CLS_LAST    = CB'(NUM_CLASSES - 1);
    localparam logic [SIZE_W:0] SMALL_LIMIT = (SIZE_W+1)'(NUM_CLASSES * 4);

    logic [HANDLE_BITS-1:0] r_heads [NUM_CLASSES];
    logic [HANDLE_BITS-1:0] r_links [LINK_DEPTH];

    logic                   r_free;
    logic [SIZE_W-1:0]      r_size;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [CB-1:0]          r_cls;
    logic [HANDLE_BITS-1:0] r_head;
    logic [HANDLE_BITS-1:0] r_link;
    logic [CB-1:0]          r_clr;

    logic                   r_out_valid;
    logic [HANDLE_W-1:0]    r_out_handle;
    logic [STATUS_W-1:0]    r_out_status;
    logic [ROUND_W-1:0]     r_out_round;

    logic [SIZE_W-1:0]           w_size_m1;
    logic [SIZE_W-3:0]           w_quarter;
    logic [CB-1:0]               w_cls_in;
    logic [HANDLE_BITS+HANDLE_W-1:0] w_hin_ext;
    logic [HANDLE_BITS+HANDLE_W-1:0] w_hout_ext;
    logic [HANDLE_BITS-1:0]      w_handle_in;
    logic [SIZE_W:0]             w_rounded;
    logic                        w_zero;
    logic                        w_small;
    t_status                     w_kind;

    // class = ceil(size/4) - 1 = (size-1) >> 2
    assign w_size_m1   = i_size_bytes - SIZE_W'(1);
    assign w_quarter   = w_size_m1[SIZE_W-1:2];
    assign w_cls_in    = w_quarter[CB-1:0];
    assign w_hin_ext   = {{HANDLE_BITS{1'b0}}, i_block_handle};
    assign w_handle_in = w_hin_ext[HANDLE_BITS-1:0];

    assign w_rounded = ({1'b0, r_size} + (SIZE_W+1)'(3)) & ~(SIZE_W+1)'(3);
    assign w_zero    = (r_size == '0);
    assign w_small   = ({1'b0, r_size} <= SMALL_LIMIT);
    assign w_hout_ext = {{HANDLE_W{1'b0}}, r_head};

    always_comb begin
        if (r_free == OP_ALLOC) begin
            if (w_zero) begin
                w_kind = ST_ZERO;
            end else if (!w_small) begin
                w_kind = ST_LARGE_ALLOC;
            end else if (r_head == '0) begin
                w_kind = ST_EMPTY;
            end else begin
                w_kind = ST_POPPED;
            end
        end else begin
            if (r_handle == '0 || w_zero) begin
                w_kind = ST_FREE_IGNORED;
            end else if (!w_small) begin
                w_kind = ST_LARGE_FREE;
            end else begin
                w_kind = ST_PUSHED;
            end
        end
    end

    // a pop needs the link of its head; only looked at while the head is fresh
    assign o_stat.clear_last = (r_clr == CLS_LAST);
    assign o_stat.need_link  = (w_kind == ST_POPPED);
    assign o_stat.out_free   = !r_out_valid || i_ready;

    // request register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_free   <= i_opcode;
            r_size   <= i_size_bytes;
            r_handle <= w_handle_in;
            r_cls    <= w_cls_in;
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr && r_clr != CLS_LAST) begin
            r_clr <= r_clr + CB'(1);
        end
    end

    // head table: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_heads[r_clr] <= '0;
        end else if (i_cmd.finish && w_kind == ST_PUSHED) begin
            r_heads[r_cls] <= r_handle;
        end else if (i_cmd.finish && w_kind == ST_POPPED) begin
            r_heads[r_cls] <= r_link;
        end
        if (i_cmd.load) begin
            r_head <= r_heads[w_cls_in];
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_kind == ST_PUSHED) begin
            r_links[r_handle] <= r_head;
        end
        if (i_cmd.link_rd) begin
            r_link <= r_links[r_head];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= w_kind;
            r_out_handle <= (w_kind == ST_POPPED) ? w_hout_ext[HANDLE_W-1:0] : '0;
            r_out_round  <= (w_kind == ST_POPPED || w_kind == ST_EMPTY || w_kind == ST_PUSHED)
                            ? w_rounded[ROUND_W-1:0] : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_granted_handle = r_out_handle;
    assign o_status         = r_out_status;
    assign o_rounded_bytes  = r_out_round;

endmodule
